[design/pgw_pkg.sv]
// pgw_pkg: types, codes and address helpers for the four-level page table walker
// no dependencies; imported by pgw_step and four_level_page_table_walker
`timescale 1ns / 1ps
`default_nettype none

package pgw_pkg;

   // widths of the translation fields
   localparam int unsigned ADDR_W      = 52;
   localparam int unsigned VA_W        = 48;
   localparam int unsigned ENTRY_W     = 64;
   localparam int unsigned ROOT_W      = 64;
   localparam int unsigned LEVEL_W     = 2;
   localparam int unsigned CODE_W      = 2;

   // stream packing
   localparam int unsigned REQ_TDATA_W = 184;
   localparam int unsigned RSP_TDATA_W = 56;

   // entry bit positions
   localparam int unsigned PRESENT_BIT = 0;
   localparam int unsigned LARGE_BIT   = 7;
   localparam int unsigned BASE_LO     = 12;
   localparam int unsigned GIG_LO      = 30;
   localparam int unsigned MEG2_LO     = 21;

   // walk levels, from the top table to the leaf table
   localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_GIG  = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MEG2 = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

   // request operation codes
   typedef enum logic [CODE_W-1:0] {
      OP_NEW   = 2'd0,
      OP_ENTRY = 2'd1,
      OP_ERROR = 2'd2
   } op_type;

   // result kinds
   typedef enum logic [CODE_W-1:0] {
      KIND_READ  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_FAULT = 2'd2
   } kind_type;

   // fault causes
   typedef enum logic [CODE_W-1:0] {
      CAUSE_NONE        = 2'd0,
      CAUSE_NOT_PRESENT = 2'd1,
      CAUSE_READ_ERROR  = 2'd2
   } cause_type;

   // one request as held in the input register
   typedef struct packed {
      logic [CODE_W-1:0]  op;
      logic [ROOT_W-1:0]  root_table;
      logic [VA_W-1:0]    virt_addr;
      logic               leaf_entry_mode;
      logic [ENTRY_W-1:0] entry_data;
   } item_type;

   // one result
   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   address;
      cause_type           fault_cause;
      logic [LEVEL_W-1:0]  walk_level;
   } result_type;

   // walk context kept between requests
   typedef struct packed {
      logic               busy;
      logic [LEVEL_W-1:0] level;
      logic [VA_W-1:0]    held_virt;
      logic               held_mode;
      logic [ADDR_W-1:0]  table_base;
   } walk_state_type;

   // nine-bit table index of a virtual address at a level
   function automatic logic [8:0] slice_index(input logic [VA_W-1:0] va,
                                              input logic [LEVEL_W-1:0] lv);
      logic [8:0] idx;
      unique case (lv)
         LEVEL_TOP:  idx = va[47:39];
         LEVEL_GIG:  idx = va[38:30];
         LEVEL_MEG2: idx = va[29:21];
         default:    idx = va[20:12];
      endcase
      return idx;
   endfunction

   // physical address of the entry for a level within a table
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [VA_W-1:0] va,
                                                    input logic [LEVEL_W-1:0] lv);
      logic [ADDR_W-1:0] offs;
      offs = {{(ADDR_W-12){1'b0}}, slice_index(va, lv), 3'b000};
      return base + offs;
   endfunction

endpackage : pgw_pkg

`default_nettype wire

[design/pgw_step.sv]
// pgw_step: one walk step, combinational: next walk context and optional result
// depends on pgw_pkg
`timescale 1ns / 1ps
`default_nettype none

module pgw_step (
   input  pgw_pkg::walk_state_type state,
   input  pgw_pkg::item_type       item,
   output pgw_pkg::walk_state_type state_next,
   output logic                    res_valid,
   output pgw_pkg::result_type     res
);
   import pgw_pkg::*;

   logic [ADDR_W-1:0] here_addr;
   logic [ADDR_W-1:0] next_base;
   logic [ADDR_W-1:0] root_base;
   logic [ADDR_W-1:0] page_addr;
   logic              present;
   logic              large_page;

   // addresses and entry flags used by the arms below
   assign here_addr  = entry_addr(state.table_base, state.held_virt, state.level);
   assign next_base  = {item.entry_data[ADDR_W-1:BASE_LO], {BASE_LO{1'b0}}};
   assign root_base  = {item.root_table[ADDR_W-1:BASE_LO], {BASE_LO{1'b0}}};
   assign present    = item.entry_data[PRESENT_BIT];
   assign large_page = item.entry_data[LARGE_BIT]
                       && (state.level == LEVEL_GIG || state.level == LEVEL_MEG2);

   // translated address of a large page; offsets fill the masked-off low bits
   always_comb begin
      if (state.level == LEVEL_GIG) begin
         page_addr = {item.entry_data[ADDR_W-1:GIG_LO], state.held_virt[GIG_LO-1:0]};
      end else begin
         page_addr = {item.entry_data[ADDR_W-1:MEG2_LO], state.held_virt[MEG2_LO-1:0]};
      end
   end

   // step decode
   always_comb begin
      state_next      = state;
      res_valid       = 1'b0;
      res.kind        = KIND_READ;
      res.address     = '0;
      res.fault_cause = CAUSE_NONE;
      res.walk_level  = state.level;
      unique case (item.op)
         OP_NEW: begin
            // start a walk, dropping any in flight
            state_next.table_base = root_base;
            state_next.held_virt  = item.virt_addr;
            state_next.held_mode  = item.leaf_entry_mode;
            state_next.level      = LEVEL_TOP;
            state_next.busy       = 1'b1;
            res_valid             = 1'b1;
            res.address           = entry_addr(root_base, item.virt_addr, LEVEL_TOP);
            res.walk_level        = LEVEL_TOP;
         end
         OP_ERROR: begin
            if (state.busy) begin
               state_next.busy = 1'b0;
               res_valid       = 1'b1;
               res.kind        = KIND_FAULT;
               res.fault_cause = CAUSE_READ_ERROR;
            end
         end
         OP_ENTRY: begin
            if (state.busy) begin
               res_valid = 1'b1;
               if (!present) begin
                  state_next.busy = 1'b0;
                  res.kind        = KIND_FAULT;
                  res.fault_cause = CAUSE_NOT_PRESENT;
               end else if (large_page) begin
                  state_next.busy = 1'b0;
                  res.kind        = KIND_DONE;
                  res.address     = state.held_mode ? here_addr : page_addr;
               end else if (state.level == LEVEL_LEAF) begin
                  state_next.busy = 1'b0;
                  res.kind        = KIND_DONE;
                  res.address     = {next_base[ADDR_W-1:BASE_LO],
                                     state.held_virt[BASE_LO-1:0]};
               end else if (state.level == LEVEL_MEG2 && state.held_mode) begin
                  // leaf entry address of a small page, leaf table not read
                  state_next.busy = 1'b0;
                  res.kind        = KIND_DONE;
                  res.address     = entry_addr(next_base, state.held_virt, LEVEL_LEAF);
                  res.walk_level  = LEVEL_LEAF;
               end else begin
                  state_next.table_base = next_base;
                  state_next.level      = state.level + 2'd1;
                  res.address           = entry_addr(next_base, state.held_virt,
                                                     state.level + 2'd1);
                  res.walk_level        = state.level + 2'd1;
               end
            end
         end
         default: begin
            // unused code: no effect
         end
      endcase
   end

endmodule : pgw_step

`default_nettype wire

[design/four_level_page_table_walker.sv]
// four_level_page_table_walker: top level, input register, walk context, result register
// depends on pgw_pkg and pgw_step
//
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | tuser op, tdata root/virt/mode/entry
// rsp     | out | rsp_tvalid/rsp_tready  | tuser kind, tdata address/cause/level
//
// one request accepted per cycle unless a stalled result holds the input register
// the input register feeds pgw_step, whose result is loaded into the output register
// reset clears the walk context and both valid flags; the walker starts idle
// a stalled result holds the output register and the input register waits behind it
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // root_table[63:0], virt_addr[111:64], leaf_entry_mode[112], entry_data[176:113], zeros
   input  wire  [pgw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // op[1:0]
   input  wire  [pgw_pkg::CODE_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // address[51:0], fault_cause[53:52], walk_level[55:54]
   output logic [pgw_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // kind[1:0]
   output logic [pgw_pkg::CODE_W-1:0]       rsp_tuser
);
   import pgw_pkg::*;

   logic           in_valid_ff, in_valid_in;
   item_type       in_item_ff, in_item_in;
   walk_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   result_type     out_res_ff, out_res_in;

   walk_state_type step_state;
   logic           step_valid;
   result_type     step_res;
   logic           out_free;
   logic           in_fire;
   logic           step_fire;

   // handshake
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_fire  = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign in_fire    = req_tvalid && req_tready;

   // unpack request
   always_comb begin
      in_item_in.op              = req_tuser;
      in_item_in.root_table      = req_tdata[63:0];
      in_item_in.virt_addr       = req_tdata[111:64];
      in_item_in.leaf_entry_mode = req_tdata[112];
      in_item_in.entry_data      = req_tdata[176:113];
   end

   pgw_step u_step (
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (step_state),
      .res_valid  (step_valid),
      .res        (step_res)
   );

   // next values
   always_comb begin
      in_valid_in  = in_fire ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);
      state_in     = step_fire ? step_state : state_ff;
      out_valid_in = step_fire ? step_valid : (out_free ? 1'b0 : out_valid_ff);
      out_res_in   = (step_fire && step_valid) ? step_res : out_res_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_fire) begin
         in_item_ff <= in_item_in;
      end
      out_res_ff <= out_res_in;
   end

   // pack result
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.kind;
   assign rsp_tdata  = {out_res_ff.walk_level, out_res_ff.fault_cause, out_res_ff.address};

   // a fault carries a cause and no address
   a_fault_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_FAULT) |->
         (rsp_tdata[ADDR_W-1:0] == '0 && rsp_tdata[ADDR_W+1:ADDR_W] != CAUSE_NONE))
      else $error("fault result with address or without cause");

   // reads and completions carry no cause
   a_no_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_FAULT) |->
         rsp_tdata[ADDR_W+1:ADDR_W] == CAUSE_NONE)
      else $error("cause set on non-fault result");

   // a finished walk leaves the walker idle
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (step_fire && step_valid && step_res.kind != KIND_READ) |=> !state_ff.busy)
      else $error("walker busy after walk ended");

   // a read request keeps the walker busy
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (step_fire && step_valid && step_res.kind == KIND_READ) |=> state_ff.busy)
      else $error("walker idle after read request");

   // entries and errors while idle give nothing
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (step_fire && !state_ff.busy && in_item_ff.op != OP_NEW) |-> !step_valid)
      else $error("result produced while idle");

endmodule : four_level_page_table_walker

`default_nettype wire
